>>> hdl/lzd_pkg.sv
package lzd_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 65536;
  localparam logic [31:0] MAGIC_WORD      = 32'h57bC_0000;
  localparam logic [16:0] ADLER_PRIME     = 17'd65521;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TOKEN   = 3'd1,
    PH_LITERAL = 3'd2,
    PH_COPY    = 3'd3,
    PH_TRAILER = 3'd4,
    PH_STOP    = 3'd5
  } phase_t;

  typedef logic [3:0] status_t;
  localparam status_t ST_DATA        = 4'd0;
  localparam status_t ST_DONE        = 4'd1;
  localparam status_t ST_BAD_MAGIC   = 4'd2;
  localparam status_t ST_TOO_LARGE   = 4'd3;
  localparam status_t ST_BAD_TOKEN   = 4'd4;
  localparam status_t ST_OVERRUN     = 4'd5;
  localparam status_t ST_BEFORE      = 4'd6;
  localparam status_t ST_BEYOND      = 4'd7;
  localparam status_t ST_LEN_BAD     = 4'd8;
  localparam status_t ST_SUM_BAD     = 4'd9;
  localparam status_t ST_BYTE_IN_CPY = 4'd10;

  localparam logic [7:0] OP_END   = 8'h05;
  localparam logic [7:0] OP_END_2 = 8'hfa;

  // total byte count of a token, keyed by its first byte (0 = illegal opcode)
  function automatic logic [2:0] token_length(input logic [7:0] b0);
    logic [2:0] n;
    n = 3'd0;
    if (b0 >= 8'h80)      n = 3'd2;
    else if (b0 >= 8'h40) n = 3'd3;
    else if (b0 >= 8'h20) n = 3'd1;
    else if (b0 >= 8'h18) n = 3'd4;
    else if (b0 >= 8'h10) n = 3'd5;
    else if (b0 >= 8'h08) n = 3'd2;
    else if (b0 == 8'h07) n = 3'd3;
    else if (b0 == 8'h06) n = 3'd5;
    else if (b0 == 8'h05) n = 3'd2;
    else if (b0 == 8'h04) n = 3'd6;
    return n;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = MAGIC_WORD[31:24];
      2'd1:    m = MAGIC_WORD[23:16];
      2'd2:    m = MAGIC_WORD[15:8];
      default: m = MAGIC_WORD[7:0];
    endcase
    return m;
  endfunction

  // (a + b) mod 65521 for a, b already reduced
  function automatic logic [15:0] adler_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ADLER_PRIME) s = s - ADLER_PRIME;
    return s[15:0];
  endfunction

endpackage

>>> hdl/lz_stream_decompressor.sv
// An input transaction reaches the result register through the decode stage,
//   then the history read data / checksum stage.
// Throughput: one input transaction per cycle unless a held result waits on out_ready; the
//   history memory has one write and one registered read port, with a bypass
//   for back-to-back copies. Reset (rst_n, synchronous): header phase, counters
//   cleared, sum_low_r = 1, sum_high_r = 0, no result pending, history kept.
module lz_stream_decompressor #(
  parameter int unsigned WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [3:0] out_status,
  output logic       out_copy_pending
);
  import lzd_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE);

  // decode stage state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  tok_r [6];
  logic [7:0]  tok_nxt [6];
  logic [16:0] lit_left_r, lit_left_nxt;
  logic [16:0] copy_left_r, copy_left_nxt;
  logic [24:0] dist_r, dist_nxt;
  logic [31:0] exp_len_r, exp_len_nxt;
  logic [32:0] produced_r, produced_nxt;
  logic [31:0] stored_sum_r, stored_sum_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt, wptr_inc;

  // stage-1 register
  logic          s1_res_r, s1_res_nxt;
  status_t       s1_status_r, s1_status_nxt;
  logic          s1_lit_r, s1_lit_nxt;
  logic [7:0]    s1_lbyte_r;
  logic          s1_push_r, s1_push_nxt;
  logic [AW-1:0] s1_waddr_r, s1_waddr_nxt;
  logic          s1_pend_r, s1_pend_nxt;
  logic          s1_sticky_r, s1_sticky_nxt;
  logic          s1_chk_r, s1_chk_nxt;
  logic          s1_lenbad_r, s1_lenbad_nxt;

  // checksum / output stage state
  logic [15:0] sum_low_r, sum_high_r;
  status_t     final_status_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  status_t     out_status_r;
  logic        out_pend_r;

  // history memory
  logic [7:0]    hist_mem [WINDOW_SIZE];
  logic [7:0]    rd_r;
  logic          fwd_r;
  logic [7:0]    fwd_byte_r;
  logic [AW-1:0] raddr;
  logic [25:0]   wpos, rpos;
  logic [7:0]    mem_data, s1_byte;
  logic [15:0]   sum_low_new;
  status_t       s2_status;

  logic advance, accept;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  // write pointer wraps at WINDOW_SIZE; a match distance never exceeds it
  assign wptr_inc = (32'(wptr_r) == WINDOW_SIZE - 32'd1) ? '0 : wptr_r + AW'(1);
  assign wpos     = 26'(wptr_r);
  assign rpos     = (wpos >= 26'(dist_r)) ? wpos - 26'(dist_r)
                                          : wpos + 26'(WINDOW_SIZE) - 26'(dist_r);
  assign raddr    = rpos[AW-1:0];
  assign mem_data = fwd_r ? fwd_byte_r : rd_r;
  assign s1_byte  = s1_lit_r ? s1_lbyte_r : mem_data;

  // token decode helpers
  logic [7:0]  t [6];
  logic [7:0]  b0;
  logic [2:0]  tlen;
  logic [16:0] len;
  logic [24:0] mdist;
  logic        is_lit;
  logic [33:0] end_cnt;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      t[i] = (cnt_r[2:0] == 3'(i)) ? in_byte : tok_r[i];
    end
    b0     = t[0];
    tlen   = token_length(b0);
    len    = '0;
    mdist  = '0;
    is_lit = 1'b0;
    if (b0 >= 8'h80) begin
      len   = 17'(b0[6:0]) + 17'd1;
      mdist = 25'(t[1]) + 25'd1;
    end else if (b0 >= 8'h40) begin
      len   = 17'(t[2]) + 17'd1;
      mdist = 25'({b0[5:0], t[1]}) + 25'd1;
    end else if (b0 >= 8'h20) begin
      len    = 17'(b0[4:0]) + 17'd1;
      is_lit = 1'b1;
    end else if (b0 >= 8'h18) begin
      len   = 17'(t[3]) + 17'd1;
      mdist = 25'({b0[2:0], t[1], t[2]}) + 25'd1;
    end else if (b0 >= 8'h10) begin
      len   = 17'({t[3], t[4]}) + 17'd1;
      mdist = 25'({b0[2:0], t[1], t[2]}) + 25'd1;
    end else if (b0 >= 8'h08) begin
      len    = 17'({b0[2:0], t[1]}) + 17'd1;
      is_lit = 1'b1;
    end else if (b0 == 8'h07) begin
      len    = 17'({t[1], t[2]}) + 17'd1;
      is_lit = 1'b1;
    end else if (b0 == 8'h06) begin
      len   = 17'(t[4]) + 17'd1;
      mdist = 25'({t[1], t[2], t[3]}) + 25'd1;
    end else begin
      len   = 17'({t[4], t[5]}) + 17'd1;
      mdist = 25'({t[1], t[2], t[3]}) + 25'd1;
    end
    end_cnt = {1'b0, produced_r} + 34'(len);
  end

  // decode stage next state
  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    for (int i = 0; i < 6; i++) tok_nxt[i] = tok_r[i];
    lit_left_nxt   = lit_left_r;
    copy_left_nxt  = copy_left_r;
    dist_nxt       = dist_r;
    exp_len_nxt    = exp_len_r;
    produced_nxt   = produced_r;
    wptr_nxt       = wptr_r;
    stored_sum_nxt = stored_sum_r;
    s1_res_nxt     = 1'b0;
    s1_status_nxt  = ST_DATA;
    s1_lit_nxt     = 1'b0;
    s1_push_nxt    = 1'b0;
    s1_waddr_nxt   = wptr_r;
    s1_pend_nxt    = 1'b0;
    s1_sticky_nxt  = 1'b0;
    s1_chk_nxt     = 1'b0;
    s1_lenbad_nxt  = 1'b0;

    if (phase_r == PH_STOP) begin
      s1_res_nxt    = 1'b1;
      s1_sticky_nxt = 1'b1;
    end else if (in_kind) begin
      if (phase_r == PH_COPY) begin
        s1_res_nxt    = 1'b1;
        s1_push_nxt   = 1'b1;
        produced_nxt  = produced_r + 33'd1;
        wptr_nxt      = wptr_inc;
        copy_left_nxt = copy_left_r - 17'd1;
        s1_pend_nxt   = (copy_left_nxt != '0);
        if (copy_left_nxt == '0) phase_nxt = PH_TOKEN;
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (cnt_r < 4'd4 && in_byte != magic_byte(cnt_r[1:0])) begin
            s1_res_nxt = 1'b1; s1_status_nxt = ST_BAD_MAGIC; phase_nxt = PH_STOP;
          end else if (cnt_r >= 4'd4 && cnt_r < 4'd8 && in_byte != 8'd0) begin
            s1_res_nxt = 1'b1; s1_status_nxt = ST_TOO_LARGE; phase_nxt = PH_STOP;
          end else begin
            if (cnt_r >= 4'd8 && cnt_r < 4'd12) exp_len_nxt = {exp_len_r[23:0], in_byte};
            if (cnt_r == 4'd15) begin
              phase_nxt = PH_TOKEN;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
        end
        PH_TOKEN: begin
          if (cnt_r == '0 && tlen == '0) begin
            s1_res_nxt = 1'b1; s1_status_nxt = ST_BAD_TOKEN; phase_nxt = PH_STOP;
          end else begin
            for (int i = 0; i < 6; i++) tok_nxt[i] = t[i];
            cnt_nxt = cnt_r + 4'd1;
            if (cnt_nxt == 4'd2 && b0 == OP_END && in_byte != OP_END_2) begin
              s1_res_nxt = 1'b1; s1_status_nxt = ST_BAD_TOKEN; phase_nxt = PH_STOP;
            end else if (cnt_nxt >= {1'b0, tlen}) begin
              cnt_nxt = '0;
              if (b0 == OP_END) begin
                phase_nxt      = PH_TRAILER;
                stored_sum_nxt = '0;
              end else if (end_cnt > {2'b0, exp_len_r}) begin
                s1_res_nxt = 1'b1; s1_status_nxt = ST_OVERRUN; phase_nxt = PH_STOP;
              end else if (is_lit) begin
                lit_left_nxt = len;
                phase_nxt    = PH_LITERAL;
              end else if ({8'd0, mdist} > produced_r) begin
                s1_res_nxt = 1'b1; s1_status_nxt = ST_BEFORE; phase_nxt = PH_STOP;
              end else if (26'(mdist) > 26'(WINDOW_SIZE)) begin
                s1_res_nxt = 1'b1; s1_status_nxt = ST_BEYOND; phase_nxt = PH_STOP;
              end else begin
                copy_left_nxt = len;
                dist_nxt      = mdist;
                phase_nxt     = PH_COPY;
              end
            end
          end
        end
        PH_LITERAL: begin
          s1_res_nxt   = 1'b1;
          s1_lit_nxt   = 1'b1;
          s1_push_nxt  = 1'b1;
          produced_nxt = produced_r + 33'd1;
          wptr_nxt     = wptr_inc;
          lit_left_nxt = lit_left_r - 17'd1;
          if (lit_left_nxt == '0) phase_nxt = PH_TOKEN;
        end
        PH_COPY: begin
          s1_res_nxt = 1'b1; s1_status_nxt = ST_BYTE_IN_CPY; phase_nxt = PH_STOP;
        end
        PH_TRAILER: begin
          stored_sum_nxt = {stored_sum_r[23:0], in_byte};
          cnt_nxt        = cnt_r + 4'd1;
          if (cnt_nxt == 4'd4) begin
            s1_res_nxt    = 1'b1;
            s1_chk_nxt    = 1'b1;
            s1_lenbad_nxt = (produced_r != {1'b0, exp_len_r});
            phase_nxt     = PH_STOP;
          end
        end
        default: begin
          s1_res_nxt    = 1'b1;
          s1_sticky_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      cnt_r        <= '0;
      for (int i = 0; i < 6; i++) tok_r[i] <= '0;
      lit_left_r   <= '0;
      copy_left_r  <= '0;
      dist_r       <= '0;
      exp_len_r    <= '0;
      produced_r   <= '0;
      wptr_r       <= '0;
      stored_sum_r <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      for (int i = 0; i < 6; i++) tok_r[i] <= tok_nxt[i];
      lit_left_r   <= lit_left_nxt;
      copy_left_r  <= copy_left_nxt;
      dist_r       <= dist_nxt;
      exp_len_r    <= exp_len_nxt;
      produced_r   <= produced_nxt;
      wptr_r       <= wptr_nxt;
      stored_sum_r <= stored_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_res_r    <= 1'b0;
      s1_push_r   <= 1'b0;
      s1_chk_r    <= 1'b0;
      s1_sticky_r <= 1'b0;
    end else if (advance) begin
      s1_res_r    <= accept && s1_res_nxt;
      s1_push_r   <= accept && s1_push_nxt;
      s1_chk_r    <= accept && s1_chk_nxt;
      s1_sticky_r <= accept && s1_sticky_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_lit_r    <= s1_lit_nxt;
      s1_lbyte_r  <= in_byte;
      s1_waddr_r  <= s1_waddr_nxt;
      s1_pend_r   <= s1_pend_nxt;
      s1_lenbad_r <= s1_lenbad_nxt;
      // bypass: the byte being written this edge is the one being read
      fwd_r       <= s1_push_r && (s1_waddr_r == raddr);
      fwd_byte_r  <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_push_r) hist_mem[s1_waddr_r] <= s1_byte;
    if (accept) rd_r <= hist_mem[raddr];
  end

  // checksum / output stage
  assign sum_low_new = adler_add(sum_low_r, {8'd0, s1_byte});

  always_comb begin
    if (s1_sticky_r)                                         s2_status = final_status_r;
    else if (s1_chk_r && s1_lenbad_r)                        s2_status = ST_LEN_BAD;
    else if (s1_chk_r && {sum_high_r, sum_low_r} != stored_sum_r) s2_status = ST_SUM_BAD;
    else if (s1_chk_r)                                       s2_status = ST_DONE;
    else                                                     s2_status = s1_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_low_r      <= 16'd1;
      sum_high_r     <= '0;
      final_status_r <= ST_DATA;
      out_valid_r    <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_res_r;
      if (s1_push_r) begin
        sum_low_r  <= sum_low_new;
        sum_high_r <= adler_add(sum_high_r, sum_low_new);
      end
      if (s1_res_r && !s1_sticky_r && s2_status != ST_DATA) final_status_r <= s2_status;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= s2_status;
      out_byte_r   <= (s2_status == ST_DATA) ? s1_byte : 8'd0;
      out_pend_r   <= (s2_status == ST_DATA) && s1_pend_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_status       = out_status_r;
  assign out_copy_pending = out_pend_r;

endmodule
